>>> rtl/oort_pkg.sv
// ----------------------------------------------------------------------------
// oort_pkg: shared types and constants of the out-of-order range tracker
// Holds result codes, the queued item type and the engine state encoding.
// ----------------------------------------------------------------------------
package oort_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 64;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned BYTES_W = 33;
  localparam int unsigned STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Item as it leaves the front queue, already classified.
  typedef struct packed {
    logic kind;
    logic inverted;
    logic [SEQ_W-1:0] range_start;
    logic [SEQ_W-1:0] range_end;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_DN,
    S_SD_WR,
    S_SHIFT_UP,
    S_SU_WR,
    S_FLUSH_RD,
    S_RESP
  } state_t;

endpackage

>>> rtl/oort_if.sv
// ----------------------------------------------------------------------------
// oort_if: request and response channels of the range tracker
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface oort_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic [oort_pkg::SEQ_W-1:0] range_start;
  logic [oort_pkg::SEQ_W-1:0] range_end;

  modport source (output valid, kind, range_start, range_end, input ready);
  modport sink (input valid, kind, range_start, range_end, output ready);
endinterface

interface oort_rsp_if;
  logic valid;
  logic ready;
  logic [oort_pkg::STATUS_W-1:0] status;
  logic [oort_pkg::BYTES_W-1:0] removed_bytes;

  modport source (output valid, status, removed_bytes, input ready);
  modport sink (input valid, status, removed_bytes, output ready);
endinterface

>>> rtl/oort_front.sv
// ----------------------------------------------------------------------------
// oort_front: request intake and classification
// Accepts request transactions, flags inverted pushes and queues up to two items.
// ----------------------------------------------------------------------------
module oort_front (
  input  logic clk,
  input  logic rst,
  oort_req_if.sink req,
  output logic q_valid,
  input  logic q_ready,
  output oort_pkg::item_t q_item
);

  oort_pkg::item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;
  oort_pkg::item_t in_item;

  always_comb begin
    in_item.kind = req.kind;
    in_item.inverted = (req.kind == oort_pkg::KIND_PUSH) && (req.range_start > req.range_end);
    in_item.range_start = req.range_start;
    in_item.range_end = req.range_end;
  end

  assign req.ready = (fill != 2'd2);
  assign push = req.valid && req.ready;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/oort_back.sv
// ----------------------------------------------------------------------------
// oort_back: range table engine
// Scans the sorted table, merges, inserts or flushes ranges, shifts entries
// by a read and a write state each; the result is held in an output register.
// ----------------------------------------------------------------------------
module oort_back #(
  parameter int unsigned CAPACITY = oort_pkg::CAPACITY_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  oort_pkg::item_t q_item,
  oort_rsp_if.source rsp
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned SW = oort_pkg::SEQ_W;
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  logic [2*SW-1:0] mem [CAPACITY];
  logic [2*SW-1:0] rdata;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [2*SW-1:0] wdata;
  logic mem_we;

  oort_pkg::state_t state, state_next;
  oort_pkg::item_t cur;
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic has_pred;
  logic has_curr;
  logic [SW-1:0] pred_s;
  logic [SW-1:0] pred_e;
  logic [SW-1:0] cur_s;
  logic [SW-1:0] cur_e;
  logic [oort_pkg::STATUS_W-1:0] res_status;
  logic [oort_pkg::BYTES_W-1:0] res_bytes;
  logic out_valid;
  logic [oort_pkg::STATUS_W-1:0] out_status;
  logic [oort_pkg::BYTES_W-1:0] out_bytes;

  logic [SW-1:0] rd_s;
  logic [SW-1:0] rd_e;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] i_dec;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] k_dec;
  logic below;
  logic overlap;
  logic join_lo;
  logic join_hi;
  logic load_out;

  assign rd_s = rdata[2*SW-1:SW];
  assign rd_e = rdata[SW-1:0];
  assign i_inc = i + 1'b1;
  assign i_dec = i - 1'b1;
  assign k_inc = k + 1'b1;
  assign k_dec = k - 1'b1;
  assign below = rd_e < cur.range_start;
  assign overlap = has_curr && (cur_s <= cur.range_end);
  assign join_lo = has_pred && ({1'b0, pred_e} + 1'b1 == {1'b0, cur.range_start});
  assign join_hi = has_curr && ({1'b0, cur.range_end} + 1'b1 == {1'b0, cur_s});
  assign load_out = (state == oort_pkg::S_RESP) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= oort_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    raddr = '0;
    mem_we = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      oort_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.kind == oort_pkg::KIND_FLUSH) begin
            state_next = (count == '0) ? oort_pkg::S_RESP : oort_pkg::S_FLUSH_RD;
          end else if (q_item.inverted) begin
            state_next = oort_pkg::S_RESP;
          end else begin
            state_next = (count == '0) ? oort_pkg::S_DECIDE : oort_pkg::S_SCAN;
          end
        end
      end
      oort_pkg::S_SCAN: begin
        if (below && (i_inc != count)) begin
          raddr = i_inc[IW-1:0];
        end else begin
          state_next = oort_pkg::S_DECIDE;
        end
      end
      oort_pkg::S_DECIDE: begin
        if (overlap) begin
          state_next = oort_pkg::S_RESP;
        end else if (join_lo && join_hi) begin
          mem_we = 1'b1;
          waddr = i_dec[IW-1:0];
          wdata = {pred_s, cur_e};
          state_next = oort_pkg::S_SHIFT_DN;
        end else if (join_lo) begin
          mem_we = 1'b1;
          waddr = i_dec[IW-1:0];
          wdata = {pred_s, cur.range_end};
          state_next = oort_pkg::S_RESP;
        end else if (join_hi) begin
          mem_we = 1'b1;
          waddr = i[IW-1:0];
          wdata = {cur.range_start, cur_e};
          state_next = oort_pkg::S_RESP;
        end else begin
          state_next = (count >= FULL) ? oort_pkg::S_RESP : oort_pkg::S_SHIFT_UP;
        end
      end
      oort_pkg::S_SHIFT_DN: begin
        if ({1'b0, k_inc} >= {1'b0, count}) begin
          state_next = oort_pkg::S_RESP;
        end else begin
          raddr = k_inc[IW-1:0];
          state_next = oort_pkg::S_SD_WR;
        end
      end
      oort_pkg::S_SD_WR: begin
        mem_we = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
        state_next = oort_pkg::S_SHIFT_DN;
      end
      oort_pkg::S_SHIFT_UP: begin
        if (k == i) begin
          mem_we = 1'b1;
          waddr = i[IW-1:0];
          wdata = {cur.range_start, cur.range_end};
          state_next = oort_pkg::S_RESP;
        end else begin
          raddr = k_dec[IW-1:0];
          state_next = oort_pkg::S_SU_WR;
        end
      end
      oort_pkg::S_SU_WR: begin
        mem_we = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
        state_next = oort_pkg::S_SHIFT_UP;
      end
      oort_pkg::S_FLUSH_RD: begin
        state_next = (rd_s == cur.range_start) ? oort_pkg::S_SHIFT_DN : oort_pkg::S_RESP;
      end
      oort_pkg::S_RESP: begin
        if (load_out) state_next = oort_pkg::S_IDLE;
      end
      default: state_next = oort_pkg::S_IDLE;
    endcase
  end

  // Datapath registers follow the state; only the table count needs reset.
  always_ff @(posedge clk) begin
    case (state)
      oort_pkg::S_IDLE: begin
        if (q_valid) begin
          cur <= q_item;
          i <= '0;
          has_pred <= 1'b0;
          has_curr <= 1'b0;
          res_bytes <= '0;
          res_status <= (q_item.kind == oort_pkg::KIND_PUSH && q_item.inverted)
                        ? oort_pkg::ST_REJECT : oort_pkg::ST_OK;
        end
      end
      oort_pkg::S_SCAN: begin
        if (below) begin
          has_pred <= 1'b1;
          pred_s <= rd_s;
          pred_e <= rd_e;
          i <= i_inc;
        end else begin
          has_curr <= 1'b1;
          cur_s <= rd_s;
          cur_e <= rd_e;
        end
      end
      oort_pkg::S_DECIDE: begin
        if (overlap) begin
          res_status <= oort_pkg::ST_REJECT;
        end else if (join_lo && join_hi) begin
          k <= i;
        end else if (!join_lo && !join_hi) begin
          if (count >= FULL) res_status <= oort_pkg::ST_NOSPACE;
          k <= count;
        end
      end
      oort_pkg::S_SD_WR: k <= k_inc;
      oort_pkg::S_SU_WR: k <= k_dec;
      oort_pkg::S_FLUSH_RD: begin
        if (rd_s == cur.range_start) begin
          res_bytes <= {1'b0, rd_e} - {1'b0, rd_s} + 1'b1;
          k <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if ((state == oort_pkg::S_SHIFT_DN) && ({1'b0, k_inc} >= {1'b0, count})) begin
      count <= count - 1'b1;
    end else if ((state == oort_pkg::S_SHIFT_UP) && (k == i)) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_bytes <= res_bytes;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.removed_bytes = out_bytes;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("range table count exceeds capacity");
  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    load_out && cur.kind == oort_pkg::KIND_FLUSH |-> res_status == oort_pkg::ST_OK)
    else $error("flush result carries a nonzero status");
  a_push_no_bytes: assert property (@(posedge clk) disable iff (rst)
    load_out && cur.kind == oort_pkg::KIND_PUSH |-> res_bytes == '0)
    else $error("push result carries flushed bytes");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> state == oort_pkg::S_IDLE)
    else $error("item taken while engine busy");

endmodule

>>> rtl/out_of_order_range_tracker.sv
// ----------------------------------------------------------------------------
// out_of_order_range_tracker: sorted table of out-of-order byte ranges
// Top level joining the request queue and the table engine.
// ----------------------------------------------------------------------------
// Requests arrive on req (kind, range_start, range_end); each gives exactly
// one response on rsp (status, removed_bytes), in request order.
// A push scans the sorted table one entry per cycle through a memory with
// one read and one write port and registered reads, then merges or inserts.
// Inserting or removing an entry shifts the entries above it, each moved
// entry through a read state and a write state.
// The engine handles one item at a time; the two-entry request queue keeps
// accepting while it works, until it is full, and the response register lets
// the next item run while a result waits. A stalled receiver holds the engine
// only once a second result is ready. Reset empties the table at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module out_of_order_range_tracker #(
  parameter int unsigned CAPACITY = oort_pkg::CAPACITY_DEFAULT
) (
  input logic clk,
  input logic rst,
  oort_req_if.sink req,
  oort_rsp_if.source rsp
);

  logic q_valid;
  logic q_ready;
  oort_pkg::item_t q_item;

  oort_front u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item(q_item)
  );

  oort_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_item(q_item),
    .rsp(rsp)
  );

endmodule
